// ----- rtl/ftacc_pkg.sv -----
// shared types, constants and saturating helpers for the force/torque accumulator
// used by every module under rtl; depends on nothing
package ftacc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ACC_WIDTH = 48;
    localparam int MAC_W     = 66;
    localparam int UF_W      = 50;
    localparam int UF_SPLIT  = 25;
    localparam int DIV_Q_W   = 34;
    localparam int NUM_W     = 64;
    localparam int NORM_BITS = 15;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 5;

    typedef logic signed [31:0]          word_t;
    typedef logic signed [ACC_WIDTH-1:0] acc_t;
    typedef logic signed [MAC_W-1:0]     mac_t;

    localparam logic [1:0] KIND_FORCE   = 2'd0;
    localparam logic [1:0] KIND_TORQUE  = 2'd1;
    localparam logic [1:0] KIND_CONTACT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS      = 3'd6;

    // multiply-accumulate program steps of the back end
    localparam logic [STEP_W-1:0] S_UU0 = 5'd0;
    localparam logic [STEP_W-1:0] S_UU1 = 5'd1;
    localparam logic [STEP_W-1:0] S_UU2 = 5'd2;
    localparam logic [STEP_W-1:0] S_UF0 = 5'd3;
    localparam logic [STEP_W-1:0] S_UF1 = 5'd4;
    localparam logic [STEP_W-1:0] S_UF2 = 5'd5;
    localparam logic [STEP_W-1:0] S_N0H = 5'd6;
    localparam logic [STEP_W-1:0] S_N0L = 5'd7;
    localparam logic [STEP_W-1:0] S_N1H = 5'd8;
    localparam logic [STEP_W-1:0] S_N1L = 5'd9;
    localparam logic [STEP_W-1:0] S_N2H = 5'd10;
    localparam logic [STEP_W-1:0] S_N2L = 5'd11;
    localparam logic [STEP_W-1:0] S_TX0 = 5'd12;
    localparam logic [STEP_W-1:0] S_TX1 = 5'd13;
    localparam logic [STEP_W-1:0] S_TY0 = 5'd14;
    localparam logic [STEP_W-1:0] S_TY1 = 5'd15;
    localparam logic [STEP_W-1:0] S_TZ0 = 5'd16;
    localparam logic [STEP_W-1:0] S_TZ1 = 5'd17;
    localparam logic [STEP_W-1:0] S_GX  = 5'd18;
    localparam logic [STEP_W-1:0] S_GY  = 5'd19;
    localparam logic [STEP_W-1:0] S_GZ  = 5'd20;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_FORCE,
        CLS_TORQUE,
        CLS_CONTACT
    } cls_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NORM,
        B_MUL,
        B_ACC,
        B_DIV,
        B_EMIT
    } bstate_t;

    typedef struct packed {
        cls_t        cls;
        logic        last;
        word_t [2:0] f;
        word_t [2:0] v;
    } item_t;

    typedef struct packed {
        word_t [2:0] frc;
        word_t [2:0] trq;
    } res_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    function automatic mac_t ext32(word_t w);
        return mac_t'(w);
    endfunction

    function automatic word_t sat32(mac_t x);
        logic fits;
        fits = (&x[MAC_W-1:31]) | ~(|x[MAC_W-1:31]);
        if (fits)
            return x[31:0];
        else if (x[MAC_W-1])
            return 32'sh8000_0000;
        else
            return 32'sh7fff_ffff;
    endfunction

    function automatic acc_t acc_add(acc_t a, mac_t b);
        logic                   fits;
        acc_t                   bc;
        logic signed [ACC_WIDTH:0] s;
        fits = (&b[MAC_W-1:ACC_WIDTH-1]) | ~(|b[MAC_W-1:ACC_WIDTH-1]);
        if (fits)
            bc = b[ACC_WIDTH-1:0];
        else if (b[MAC_W-1])
            bc = ACC_MIN;
        else
            bc = ACC_MAX;
        s = {a[ACC_WIDTH-1], a} + {bc[ACC_WIDTH-1], bc};
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
            return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        else
            return s[ACC_WIDTH-1:0];
    endfunction

endpackage

// ----- rtl/ftacc_front.sv -----
// front end: classifies an incoming word and forms the contact offset
// depends on ftacc_pkg
module ftacc_front (
    input  logic [1:0]            req_type,
    input  logic                  last_item,
    input  ftacc_pkg::word_t [2:0] vec,
    input  ftacc_pkg::word_t [2:0] point,
    input  ftacc_pkg::word_t [2:0] center,
    output ftacc_pkg::item_t      item
);

    ftacc_pkg::word_t [2:0] v;
    logic                   nz;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v[i] = ftacc_pkg::sat32(ftacc_pkg::ext32(center[i]) - ftacc_pkg::ext32(point[i]));
        end
        nz = |{v[0], v[1], v[2]};
    end

    always_comb
    begin
        item.last = last_item;
        item.f    = vec;
        item.v    = v;
        unique case (req_type)
            ftacc_pkg::KIND_FORCE:   item.cls = ftacc_pkg::CLS_FORCE;
            ftacc_pkg::KIND_TORQUE:  item.cls = ftacc_pkg::CLS_TORQUE;
            ftacc_pkg::KIND_CONTACT: item.cls = nz ? ftacc_pkg::CLS_CONTACT : ftacc_pkg::CLS_FORCE;
            default:                 item.cls = ftacc_pkg::CLS_NONE;
        endcase
    end

endmodule

// ----- rtl/ftacc_fifo.sv -----
// two-entry queue of classified words between front and back end
// depends on ftacc_pkg
module ftacc_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  ftacc_pkg::item_t wr_item,
    output logic             full,
    input  logic             rd_en,
    output ftacc_pkg::item_t rd_item,
    output logic             empty
);

    ftacc_pkg::item_t mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- rtl/ftacc_div.sv -----
// restoring divider, one quotient bit per cycle, unsigned magnitudes
// depends on ftacc_pkg; quotient known to fit DIV_Q_W bits
module ftacc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ftacc_pkg::NUM_W-1:0]    num,
    input  logic [31:0]                    den,
    output logic                           done,
    output logic [ftacc_pkg::DIV_Q_W-1:0]  quo
);

    localparam int CNT_W = $clog2(ftacc_pkg::DIV_Q_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [31:0]                   rem_reg;
    logic [ftacc_pkg::DIV_Q_W-1:0] nb_reg;
    logic [ftacc_pkg::DIV_Q_W-1:0] q_reg;
    logic [32:0]                   trial;
    logic [32:0]                   diff;
    logic                          ge;

    assign trial = {rem_reg, nb_reg[ftacc_pkg::DIV_Q_W-1]};
    assign ge    = (trial >= {1'b0, den});
    assign diff  = trial - {1'b0, den};
    assign done  = done_reg;
    assign quo   = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ftacc_pkg::DIV_Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 32'(num[ftacc_pkg::NUM_W-1:ftacc_pkg::DIV_Q_W]);
            nb_reg  <= num[ftacc_pkg::DIV_Q_W-1:0];
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            nb_reg  <= {nb_reg[ftacc_pkg::DIV_Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[ftacc_pkg::DIV_Q_W-2:0], ge};
        end
    end

endmodule

// ----- rtl/ftacc_back.sv -----
// back end: sequencer over a shared multiplier, accumulator and divider
// depends on ftacc_pkg and ftacc_div; holds the running totals and result word
module ftacc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  ftacc_pkg::item_t       q_item,
    output logic                   q_pop,
    input  ftacc_pkg::word_t [2:0] gravity,
    input  logic [31:0]            mass,
    input  logic                   res_pop,
    output logic                   res_empty,
    output ftacc_pkg::res_t        res
);

    ftacc_pkg::bstate_t           st_reg, st_next;
    ftacc_pkg::item_t             item_reg, item_next;
    logic [2:0][31:0]             mag_reg, mag_next;
    logic [31:0]                  m_reg, m_next;
    logic [ftacc_pkg::STEP_W-1:0] step_reg, step_next;
    ftacc_pkg::mac_t              prod_reg, prod_next;
    ftacc_pkg::mac_t              mac_reg, mac_next;
    logic [31:0]                  uu_reg, uu_next;
    logic signed [ftacc_pkg::UF_W-1:0] uf_reg, uf_next;
    ftacc_pkg::word_t [2:0]       perp_reg, perp_next;
    ftacc_pkg::acc_t [2:0]        frc_reg, frc_next;
    ftacc_pkg::acc_t [2:0]        trq_reg, trq_next;
    ftacc_pkg::res_t              res_reg, res_next;
    logic                         res_valid_reg, res_valid_next;
    logic                         neg_reg, neg_next;

    logic                                div_start;
    logic [ftacc_pkg::NUM_W-1:0]         div_num;
    logic                                div_done;
    logic [ftacc_pkg::DIV_Q_W-1:0]       div_q;

    logic signed [15:0] u [3];
    logic signed [32:0] mul_a, mul_b;
    logic               first, negate, shifted;
    ftacc_pkg::mac_t    term, mac_sum, nmag;
    logic [1:0]         pidx;
    logic signed [ftacc_pkg::DIV_Q_W:0] par;

    ftacc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (uu_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    assign q_pop     = (st_reg == ftacc_pkg::B_IDLE) && !q_empty;
    assign res_empty = !res_valid_reg;
    assign res       = res_reg;

    // reduced offset, valid once normalization is over
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u[i] = item_reg.v[i][31] ? -$signed({1'b0, mag_reg[i][14:0]})
                                     : $signed({1'b0, mag_reg[i][14:0]});
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            ftacc_pkg::S_UU0: begin mul_a = 33'(u[0]); mul_b = 33'(u[0]); end
            ftacc_pkg::S_UU1: begin mul_a = 33'(u[1]); mul_b = 33'(u[1]); end
            ftacc_pkg::S_UU2: begin mul_a = 33'(u[2]); mul_b = 33'(u[2]); end
            ftacc_pkg::S_UF0: begin mul_a = 33'(u[0]); mul_b = 33'(item_reg.f[0]); end
            ftacc_pkg::S_UF1: begin mul_a = 33'(u[1]); mul_b = 33'(item_reg.f[1]); end
            ftacc_pkg::S_UF2: begin mul_a = 33'(u[2]); mul_b = 33'(item_reg.f[2]); end
            ftacc_pkg::S_N0H: begin mul_a = 33'(u[0]); mul_b = 33'($signed(uf_reg[49:25])); end
            ftacc_pkg::S_N0L: begin mul_a = 33'(u[0]); mul_b = {8'b0, uf_reg[24:0]}; end
            ftacc_pkg::S_N1H: begin mul_a = 33'(u[1]); mul_b = 33'($signed(uf_reg[49:25])); end
            ftacc_pkg::S_N1L: begin mul_a = 33'(u[1]); mul_b = {8'b0, uf_reg[24:0]}; end
            ftacc_pkg::S_N2H: begin mul_a = 33'(u[2]); mul_b = 33'($signed(uf_reg[49:25])); end
            ftacc_pkg::S_N2L: begin mul_a = 33'(u[2]); mul_b = {8'b0, uf_reg[24:0]}; end
            ftacc_pkg::S_TX0: begin mul_a = 33'(perp_reg[1]); mul_b = 33'(item_reg.v[2]); end
            ftacc_pkg::S_TX1: begin mul_a = 33'(perp_reg[2]); mul_b = 33'(item_reg.v[1]); end
            ftacc_pkg::S_TY0: begin mul_a = 33'(perp_reg[2]); mul_b = 33'(item_reg.v[0]); end
            ftacc_pkg::S_TY1: begin mul_a = 33'(perp_reg[0]); mul_b = 33'(item_reg.v[2]); end
            ftacc_pkg::S_TZ0: begin mul_a = 33'(perp_reg[0]); mul_b = 33'(item_reg.v[1]); end
            ftacc_pkg::S_TZ1: begin mul_a = 33'(perp_reg[1]); mul_b = 33'(item_reg.v[0]); end
            ftacc_pkg::S_GX:  begin mul_a = 33'(gravity[0]); mul_b = {1'b0, mass}; end
            ftacc_pkg::S_GY:  begin mul_a = 33'(gravity[1]); mul_b = {1'b0, mass}; end
            ftacc_pkg::S_GZ:  begin mul_a = 33'(gravity[2]); mul_b = {1'b0, mass}; end
            default:          begin mul_a = '0; mul_b = '0; end
        endcase
        first   = (step_reg == ftacc_pkg::S_UU0) || (step_reg == ftacc_pkg::S_UF0) ||
                  (step_reg == ftacc_pkg::S_N0H) || (step_reg == ftacc_pkg::S_N1H) ||
                  (step_reg == ftacc_pkg::S_N2H) || (step_reg == ftacc_pkg::S_TX0) ||
                  (step_reg == ftacc_pkg::S_TY0) || (step_reg == ftacc_pkg::S_TZ0) ||
                  (step_reg == ftacc_pkg::S_GX)  || (step_reg == ftacc_pkg::S_GY)  ||
                  (step_reg == ftacc_pkg::S_GZ);
        negate  = (step_reg == ftacc_pkg::S_TX1) || (step_reg == ftacc_pkg::S_TY1) ||
                  (step_reg == ftacc_pkg::S_TZ1);
        shifted = (step_reg == ftacc_pkg::S_N0H) || (step_reg == ftacc_pkg::S_N1H) ||
                  (step_reg == ftacc_pkg::S_N2H);
        term    = shifted ? (prod_reg <<< ftacc_pkg::UF_SPLIT) : prod_reg;
        term    = negate ? -term : term;
        mac_sum = (first ? ftacc_pkg::mac_t'(0) : mac_reg) + term;
        nmag    = mac_sum[ftacc_pkg::MAC_W-1] ? -mac_sum : mac_sum;
        par     = neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        unique case (step_reg)
            ftacc_pkg::S_N1H: pidx = 2'd0;
            ftacc_pkg::S_N2H: pidx = 2'd1;
            default:          pidx = 2'd2;
        endcase
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ftacc_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_item.cls == ftacc_pkg::CLS_CONTACT)
                        st_next = ftacc_pkg::B_NORM;
                    else if (q_item.last)
                        st_next = ftacc_pkg::B_MUL;
                end
            end
            ftacc_pkg::B_NORM:
            begin
                if (m_reg[31:ftacc_pkg::NORM_BITS] == '0)
                    st_next = ftacc_pkg::B_MUL;
            end
            ftacc_pkg::B_MUL:
            begin
                st_next = ftacc_pkg::B_ACC;
            end
            ftacc_pkg::B_ACC:
            begin
                unique case (step_reg)
                    ftacc_pkg::S_N0L, ftacc_pkg::S_N1L, ftacc_pkg::S_N2L:
                        st_next = ftacc_pkg::B_DIV;
                    ftacc_pkg::S_TZ1:
                        st_next = item_reg.last ? ftacc_pkg::B_MUL : ftacc_pkg::B_IDLE;
                    ftacc_pkg::S_GZ:
                        st_next = ftacc_pkg::B_EMIT;
                    default:
                        st_next = ftacc_pkg::B_MUL;
                endcase
            end
            ftacc_pkg::B_DIV:
            begin
                if (div_done)
                    st_next = ftacc_pkg::B_MUL;
            end
            ftacc_pkg::B_EMIT:
            begin
                if (!res_valid_reg || res_pop)
                    st_next = ftacc_pkg::B_IDLE;
            end
            default:
            begin
                st_next = ftacc_pkg::B_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        item_next      = item_reg;
        mag_next       = mag_reg;
        m_next         = m_reg;
        step_next      = step_reg;
        prod_next      = prod_reg;
        mac_next       = mac_reg;
        uu_next        = uu_reg;
        uf_next        = uf_reg;
        perp_next      = perp_reg;
        frc_next       = frc_reg;
        trq_next       = trq_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_pop;
        neg_next       = neg_reg;
        div_start      = 1'b0;
        div_num        = nmag[ftacc_pkg::NUM_W-1:0];
        unique case (st_reg)
            ftacc_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    item_next = q_item;
                    step_next = q_item.cls == ftacc_pkg::CLS_CONTACT ? ftacc_pkg::S_UU0
                                                                       : ftacc_pkg::S_GX;
                    unique case (q_item.cls)
                        ftacc_pkg::CLS_FORCE:
                        begin
                            for (int i = 0; i < 3; i++)
                                frc_next[i] = ftacc_pkg::acc_add(frc_reg[i],
                                                  ftacc_pkg::ext32(q_item.f[i]));
                        end
                        ftacc_pkg::CLS_TORQUE:
                        begin
                            for (int i = 0; i < 3; i++)
                                trq_next[i] = ftacc_pkg::acc_add(trq_reg[i],
                                                  ftacc_pkg::ext32(q_item.f[i]));
                        end
                        ftacc_pkg::CLS_CONTACT:
                        begin
                            for (int i = 0; i < 3; i++)
                                mag_next[i] = q_item.v[i][31] ? 32'(-q_item.v[i])
                                                              : 32'(q_item.v[i]);
                            m_next = (mag_next[0] > mag_next[1]) ? mag_next[0] : mag_next[1];
                            m_next = (mag_next[2] > m_next) ? mag_next[2] : m_next;
                        end
                        default:
                        begin
                            item_next = q_item;
                        end
                    endcase
                end
            end
            ftacc_pkg::B_NORM:
            begin
                if (m_reg[31:ftacc_pkg::NORM_BITS] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_next[i] = mag_reg[i] >> 1;
                    m_next = m_reg >> 1;
                end
            end
            ftacc_pkg::B_MUL:
            begin
                prod_next = mul_a * mul_b;
            end
            ftacc_pkg::B_ACC:
            begin
                mac_next  = mac_sum;
                step_next = step_reg + ftacc_pkg::STEP_W'(1);
                unique case (step_reg)
                    ftacc_pkg::S_UU2: uu_next = mac_sum[31:0];
                    ftacc_pkg::S_UF2: uf_next = mac_sum[ftacc_pkg::UF_W-1:0];
                    ftacc_pkg::S_N0L, ftacc_pkg::S_N1L, ftacc_pkg::S_N2L:
                    begin
                        div_start = 1'b1;
                        neg_next  = mac_sum[ftacc_pkg::MAC_W-1];
                    end
                    ftacc_pkg::S_TX1:
                        trq_next[0] = ftacc_pkg::acc_add(trq_reg[0],
                                          mac_sum >>> ftacc_pkg::FRAC_BITS);
                    ftacc_pkg::S_TY1:
                        trq_next[1] = ftacc_pkg::acc_add(trq_reg[1],
                                          mac_sum >>> ftacc_pkg::FRAC_BITS);
                    ftacc_pkg::S_TZ1:
                    begin
                        trq_next[2] = ftacc_pkg::acc_add(trq_reg[2],
                                          mac_sum >>> ftacc_pkg::FRAC_BITS);
                        step_next   = ftacc_pkg::S_GX;
                    end
                    ftacc_pkg::S_GX:
                        frc_next[0] = ftacc_pkg::acc_add(frc_reg[0],
                                          mac_sum >>> ftacc_pkg::FRAC_BITS);
                    ftacc_pkg::S_GY:
                        frc_next[1] = ftacc_pkg::acc_add(frc_reg[1],
                                          mac_sum >>> ftacc_pkg::FRAC_BITS);
                    ftacc_pkg::S_GZ:
                        frc_next[2] = ftacc_pkg::acc_add(frc_reg[2],
                                          mac_sum >>> ftacc_pkg::FRAC_BITS);
                    default:
                        mac_next = mac_sum;
                endcase
            end
            ftacc_pkg::B_DIV:
            begin
                if (div_done)
                begin
                    frc_next[pidx]  = ftacc_pkg::acc_add(frc_reg[pidx],
                                          ftacc_pkg::mac_t'(par));
                    perp_next[pidx] = ftacc_pkg::sat32(ftacc_pkg::ext32(item_reg.f[pidx])
                                          - ftacc_pkg::mac_t'(par));
                end
            end
            ftacc_pkg::B_EMIT:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        res_next.frc[i] = ftacc_pkg::sat32(ftacc_pkg::mac_t'(frc_reg[i]));
                        res_next.trq[i] = ftacc_pkg::sat32(ftacc_pkg::mac_t'(trq_reg[i]));
                        frc_next[i]     = '0;
                        trq_next[i]     = '0;
                    end
                    res_valid_next = 1'b1;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ftacc_pkg::B_IDLE;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
            frc_reg       <= '0;
            trq_reg       <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
            frc_reg       <= frc_next;
            trq_reg       <= trq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        mag_reg  <= mag_next;
        m_reg    <= m_next;
        prod_reg <= prod_next;
        mac_reg  <= mac_next;
        uu_reg   <= uu_next;
        uf_reg   <= uf_next;
        perp_reg <= perp_next;
        res_reg  <= res_next;
        neg_reg  <= neg_next;
    end

endmodule

// ----- rtl/force_torque_accumulator_core.sv -----
// top level of the rigid body force/torque accumulator
// depends on ftacc_pkg, ftacc_front, ftacc_fifo, ftacc_back
//
// usage: input words enter through push/full; one word is a plain force, a plain
// torque or a contact force with its point of application (Q16.16). the word with
// last_item set closes the tick: gravity times mass is added, both totals are put
// out through empty/pop saturated to 32 bits, and the totals clear.
// configuration goes through cfg_valid/cfg_ready (always ready) with cfg_index
// selecting center, gravity or mass; write it only while the block is idle.
// the back end handles one word at a time, taken from the queue while idle. a plain
// word is summed as it is taken; a contact word runs offset normalization, then 18
// multiply-accumulate steps on the shared multiplier and three passes of the divider.
// closing a tick adds the gravity steps, then loads the result word.
// a two-entry queue lets the front take words while the back end is busy.
// reset: totals clear, center and gravity go to zero, mass to 1.0.
// a stalled result word holds; the back end keeps working on later words and
// waits only when it has a second result to hand over.
module force_torque_accumulator_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [1:0]                           req_type,
    input  logic signed [31:0]                   vec_x,
    input  logic signed [31:0]                   vec_y,
    input  logic signed [31:0]                   vec_z,
    input  logic signed [31:0]                   point_x,
    input  logic signed [31:0]                   point_y,
    input  logic signed [31:0]                   point_z,
    input  logic                                 last_item,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [31:0]                   net_force_x,
    output logic signed [31:0]                   net_force_y,
    output logic signed [31:0]                   net_force_z,
    output logic signed [31:0]                   net_torque_x,
    output logic signed [31:0]                   net_torque_y,
    output logic signed [31:0]                   net_torque_z,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ftacc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                          cfg_data
);

    ftacc_pkg::word_t [2:0] center_reg;
    ftacc_pkg::word_t [2:0] gravity_reg;
    logic [31:0]            mass_reg;
    ftacc_pkg::item_t       front_item;
    ftacc_pkg::item_t       q_item;
    logic                   q_empty;
    logic                   q_pop;
    ftacc_pkg::res_t        res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg  <= '0;
            gravity_reg <= '0;
            mass_reg    <= 32'h0001_0000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ftacc_pkg::CFG_CENTER_X:  center_reg[0]  <= cfg_data;
                ftacc_pkg::CFG_CENTER_Y:  center_reg[1]  <= cfg_data;
                ftacc_pkg::CFG_CENTER_Z:  center_reg[2]  <= cfg_data;
                ftacc_pkg::CFG_GRAVITY_X: gravity_reg[0] <= cfg_data;
                ftacc_pkg::CFG_GRAVITY_Y: gravity_reg[1] <= cfg_data;
                ftacc_pkg::CFG_GRAVITY_Z: gravity_reg[2] <= cfg_data;
                ftacc_pkg::CFG_MASS:      mass_reg       <= cfg_data;
                default:                  mass_reg       <= mass_reg;
            endcase
        end
    end

    ftacc_front u_front (
        .req_type  (req_type),
        .last_item (last_item),
        .vec       ({vec_z, vec_y, vec_x}),
        .point     ({point_z, point_y, point_x}),
        .center    (center_reg),
        .item      (front_item)
    );

    ftacc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_item (front_item),
        .full    (full),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .empty   (q_empty)
    );

    ftacc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .gravity   (gravity_reg),
        .mass      (mass_reg),
        .res_pop   (pop),
        .res_empty (empty),
        .res       (res)
    );

    assign net_force_x  = res.frc[0];
    assign net_force_y  = res.frc[1];
    assign net_force_z  = res.frc[2];
    assign net_torque_x = res.trq[0];
    assign net_torque_y = res.trq[1];
    assign net_torque_z = res.trq[2];

endmodule
